### design/tmprof_pkg.sv
package tmprof_pkg;

	localparam int SPEED_FRAC_BITS = 12;
	localparam int SPEED_W         = 15;
	localparam int COUNT_IN_W      = 32;
	localparam int SCALE_W         = 32;
	localparam int AMOUNT_W        = 16;
	localparam int OUT_W           = 16;
	localparam int CFG_IDX_W       = 8;
	localparam int CFG_DATA_W      = 32;
	localparam int GAIN_SHIFT      = 16;
	// serial multiplier digit operand: |amount| and 3*|vm - k| both fit in 17 bits
	localparam int MUL_AW          = 17;
	// quotient bits kept; anything at or above 2^15 clamps the speed anyway
	localparam int QUO_W           = 15;

	localparam logic [SPEED_W-1:0] START_SPEED_RST =
		SPEED_W'(((1 << SPEED_FRAC_BITS) + 5) / 10);
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = SPEED_W'(1 << (SPEED_FRAC_BITS - 1));
	localparam logic signed [SCALE_W-1:0] TURN_SCALE_RST    = -32'sd1970500;
	localparam logic signed [SCALE_W-1:0] ADVANCE_SCALE_RST = 32'sd4551400;

	localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_SCALE    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_SCALE = CFG_IDX_W'(3);

	localparam logic KIND_CMD     = 1'b0;
	localparam logic KIND_TICK    = 1'b1;
	localparam logic MOVE_TURN    = 1'b0;
	localparam logic MOVE_ADVANCE = 1'b1;

	typedef struct packed {
		logic                         kind;
		logic                         move_kind;
		logic signed [AMOUNT_W-1:0]   amount;
		logic signed [COUNT_IN_W-1:0] left_count;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] left_speed;
		logic signed [OUT_W-1:0] right_speed;
		logic                    done_res;
	} res_t;

endpackage

### design/trapezoid_move_profiler_core.sv
// channel  | handshake             | word
// ---------+-----------------------+--------------------------------------------
// item     | item_valid/item_stall | item_t: command or tick with encoder count
// res      | res_valid/res_stall   | res_t: left/right speed, done flag
// cfg      | cfg_valid/cfg_ready   | cfg_index, cfg_data (register write)
//
// Command: accept, a bit-serial multiply of |amount| by |gain|, then back to idle.
// Ramp tick: accept, prep, eval, bit-serial multiply, bit-serial divide, then the
// output state; cruise and done ticks go from eval straight to output; ignored
// ticks are only accepted and give no result.
// Reset restores the register defaults and an idle move; no sweep is needed.
// The result sits in an output register; a stalled result holds the next item at S_OUT.
module trapezoid_move_profiler_core
	import tmprof_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PW  = (COUNT_WIDTH < COUNT_IN_W + 1) ? COUNT_WIDTH : COUNT_IN_W + 1;
	localparam int MBW = (PW > SCALE_W) ? PW : SCALE_W;
	localparam int PRW = MUL_AW + MBW;
	localparam int XW  = (PW + 3 > SCALE_W + 2) ? PW + 3 : SCALE_W + 2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LATCH,
		PH_UP,
		PH_CRUISE,
		PH_DOWN
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMD_MUL,
		S_PREP,
		S_EVAL,
		S_RAMP_MUL,
		S_DIV,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		ACT_RAMP,
		ACT_CRUISE,
		ACT_DONE
	} act_t;

	state_t                       state_q;
	phase_t                       phase_q;
	logic [SPEED_W-1:0]           start_speed_q;
	logic [SPEED_W-1:0]           max_speed_q;
	logic signed [SCALE_W-1:0]    turn_scale_q;
	logic signed [SCALE_W-1:0]    advance_scale_q;
	logic                         turn_q;
	logic                         dneg_q;
	logic [SCALE_W-1:0]           e_q;
	logic signed [COUNT_IN_W-1:0] start_count_q;
	logic                         cmd_neg_q;
	logic                         cmd_adv_q;
	logic signed [PW-1:0]         p_q;
	logic signed [PW:0]           q_q;
	logic [PW-1:0]                aq_q;
	logic [SPEED_W-1:0]           mag_q;
	logic                         done_q;
	logic                         flip_q;
	logic                         res_valid_q;
	res_t                         res_q;

	// command operands
	logic signed [MUL_AW-1:0]     amt_x;
	logic [MUL_AW-1:0]            amt_abs;
	logic signed [SCALE_W-1:0]    scale_sel;
	logic signed [SCALE_W:0]      scale_x;
	logic [SCALE_W:0]             scale_mag;
	logic [MBW-1:0]               scale_b;
	logic                         cmd_neg;
	logic [PRW-1:0]               rnd_sum;
	logic [SCALE_W-1:0]           e_cmd;

	// tick path
	logic signed [COUNT_IN_W:0]   cnt_diff;
	logic signed [PW:0]           p_x;
	logic [PW:0]                  aq_w;
	logic signed [XW-1:0]         q_x;
	logic signed [XW-1:0]         q3;
	logic signed [XW-1:0]         e_x;
	logic signed [XW-1:0]         e2;
	logic                         lt1;
	logic                         lt2;
	logic                         lt3;
	logic [MBW-1:0]               aq_b;
	logic                         ediff_neg;
	logic [MBW-1:0]               ediff;
	logic signed [SPEED_W:0]      diffks;
	logic [SPEED_W:0]             absd;
	logic                         dir_up;
	logic                         ramp_add;
	logic [MUL_AW-1:0]            m3;
	phase_t                       ev_phase;
	act_t                         ev_act;
	logic [MBW-1:0]               ev_b;
	logic                         ev_flip;

	// units
	logic                         mul_start;
	logic [MUL_AW-1:0]            mul_a;
	logic [MBW-1:0]               mul_b;
	logic                         mul_done;
	logic [PRW-1:0]               mul_prod;
	logic                         div_start;
	logic                         div_done;
	logic [QUO_W-1:0]             div_quo;
	logic                         div_sat;

	logic signed [SPEED_W+2:0]    ks_x;
	logic signed [SPEED_W+2:0]    quo_x;
	logic signed [SPEED_W+2:0]    mag_sum;
	logic [SPEED_W-1:0]           mag_new;
	logic signed [OUT_W-1:0]      mag_s;
	logic signed [OUT_W-1:0]      sv;
	logic signed [OUT_W-1:0]      rv;
	res_t                         res_new;
	logic                         item_acc;
	logic                         res_load;

	assign item_stall = (state_q != S_IDLE);
	assign item_acc   = item_valid && (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign res_load   = (state_q == S_OUT) && (!res_valid_q || !res_stall);

	// command: |amount| * |gain|, sign applied afterwards as a floor
	assign amt_x     = MUL_AW'(item.amount);
	assign amt_abs   = amt_x[MUL_AW-1] ? MUL_AW'(-amt_x) : MUL_AW'(amt_x);
	assign scale_sel = (item.move_kind == MOVE_ADVANCE) ? advance_scale_q : turn_scale_q;
	assign scale_x   = (SCALE_W + 1)'(scale_sel);
	assign scale_mag = scale_x[SCALE_W] ? (SCALE_W + 1)'(-scale_x) : (SCALE_W + 1)'(scale_x);
	assign scale_b   = MBW'(scale_mag[SCALE_W-1:0]);
	assign cmd_neg   = item.amount[AMOUNT_W-1] ^ scale_sel[SCALE_W-1];
	// |floor(-P/2^16)| = ceil(P/2^16); the delta always fits 32 bits
	assign rnd_sum   = mul_prod + (cmd_neg_q ? PRW'((1 << GAIN_SHIFT) - 1) : PRW'(0));
	assign e_cmd     = rnd_sum[GAIN_SHIFT+SCALE_W-1:GAIN_SHIFT];

	assign cnt_diff = (COUNT_IN_W + 1)'(item.left_count) - (COUNT_IN_W + 1)'(start_count_q);

	assign p_x  = (PW + 1)'(p_q);
	assign aq_w = p_x[PW] ? (PW + 1)'(-p_x) : (PW + 1)'(p_x);

	assign q_x   = XW'(q_q);
	assign q3    = q_x + (q_x <<< 1);
	assign e_x   = XW'(e_q);
	assign e2    = e_x <<< 1;
	assign lt1   = (q3 < e_x);
	assign lt2   = (q3 < e2);
	assign lt3   = (q_x < e_x);
	assign aq_b  = MBW'(aq_q);
	// encoder far behind on the ramp-down: e - |q| goes negative
	assign ediff_neg = (MBW'(aq_q) > MBW'(e_q));
	assign ediff     = ediff_neg ? (MBW'(aq_q) - MBW'(e_q)) : (MBW'(e_q) - MBW'(aq_q));

	assign diffks = $signed({1'b0, max_speed_q}) - $signed({1'b0, start_speed_q});
	assign dir_up = !diffks[SPEED_W];
	assign absd   = diffks[SPEED_W] ? (SPEED_W + 1)'(-diffks) : (SPEED_W + 1)'(diffks);
	assign m3     = MUL_AW'(absd) + MUL_AW'({absd, 1'b0});

	// phase tests run in order on the same tick; phases only move forward
	always_comb begin
		logic hit;
		hit      = 1'b0;
		ev_phase = phase_q;
		ev_act   = ACT_DONE;
		ev_b     = aq_b;
		ev_flip  = 1'b0;
		if (e_q == '0) begin
			hit = 1'b1;
		end
		if (!hit && ev_phase == PH_UP) begin
			if (lt1) begin
				ev_act = ACT_RAMP;
				hit    = 1'b1;
			end else begin
				ev_phase = PH_CRUISE;
			end
		end
		if (!hit && ev_phase == PH_CRUISE) begin
			if (lt2) begin
				ev_act = ACT_CRUISE;
				hit    = 1'b1;
			end else begin
				ev_phase = PH_DOWN;
			end
		end
		if (!hit && ev_phase == PH_DOWN && lt3) begin
			ev_act  = ACT_RAMP;
			ev_b    = ediff;
			ev_flip = ediff_neg;
		end
		if (ev_act == ACT_DONE) begin
			ev_phase = PH_IDLE;
		end
	end

	assign mul_start = (item_acc && item.kind == KIND_CMD) ||
		(state_q == S_EVAL && ev_act == ACT_RAMP);
	assign mul_a     = (state_q == S_IDLE) ? amt_abs : m3;
	assign mul_b     = (state_q == S_IDLE) ? scale_b : ev_b;
	assign div_start = (state_q == S_RAMP_MUL) && mul_done;

	tmprof_mul #(
		.A_W (MUL_AW),
		.B_W (MBW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	tmprof_div #(
		.N_W (PRW),
		.D_W (SCALE_W),
		.Q_W (QUO_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_prod),
		.den    (e_q),
		.done   (div_done),
		.quo    (div_quo),
		.sat    (div_sat)
	);

	// k +/- quotient, clamped to 0..32767
	assign ramp_add = dir_up ^ flip_q;
	assign ks_x     = (SPEED_W + 3)'(start_speed_q);
	assign quo_x    = (SPEED_W + 3)'(div_quo);
	assign mag_sum  = ramp_add ? (ks_x + quo_x) : (ks_x - quo_x);

	always_comb begin
		if (div_sat) begin
			mag_new = ramp_add ? '1 : '0;
		end else if (mag_sum[SPEED_W+2]) begin
			mag_new = '0;
		end else if (|mag_sum[SPEED_W+1:SPEED_W]) begin
			mag_new = '1;
		end else begin
			mag_new = mag_sum[SPEED_W-1:0];
		end
	end

	assign mag_s = OUT_W'(mag_q);
	assign sv    = dneg_q ? OUT_W'(-mag_s) : mag_s;
	assign rv    = turn_q ? OUT_W'(-sv) : sv;

	always_comb begin
		if (done_q) begin
			res_new.left_speed  = '0;
			res_new.right_speed = '0;
			res_new.done_res    = 1'b1;
		end else begin
			res_new.left_speed  = sv;
			res_new.right_speed = rv;
			res_new.done_res    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			phase_q         <= PH_IDLE;
			start_speed_q   <= START_SPEED_RST;
			max_speed_q     <= MAX_SPEED_RST;
			turn_scale_q    <= TURN_SCALE_RST;
			advance_scale_q <= ADVANCE_SCALE_RST;
			turn_q          <= 1'b0;
			dneg_q          <= 1'b0;
			e_q             <= '0;
			start_count_q   <= '0;
			cmd_neg_q       <= 1'b0;
			cmd_adv_q       <= 1'b0;
			p_q             <= '0;
			q_q             <= '0;
			aq_q            <= '0;
			mag_q           <= '0;
			done_q          <= 1'b0;
			flip_q          <= 1'b0;
			res_valid_q     <= 1'b0;
			res_q           <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_SPEED: begin
						start_speed_q <= cfg_data[SPEED_W-1:0];
					end
					CFG_MAX_SPEED: begin
						max_speed_q <= cfg_data[SPEED_W-1:0];
					end
					CFG_TURN_SCALE: begin
						turn_scale_q <= $signed(cfg_data[SCALE_W-1:0]);
					end
					CFG_ADVANCE_SCALE: begin
						advance_scale_q <= $signed(cfg_data[SCALE_W-1:0]);
					end
					default: ;
				endcase
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
				res_q       <= res_new;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (item.kind == KIND_CMD) begin
							cmd_neg_q <= cmd_neg;
							cmd_adv_q <= item.move_kind;
							state_q   <= S_CMD_MUL;
						end else if (phase_q == PH_LATCH) begin
							start_count_q <= item.left_count;
							p_q           <= '0;
							phase_q       <= PH_UP;
							state_q       <= S_PREP;
						end else if (phase_q != PH_IDLE) begin
							p_q     <= cnt_diff[PW-1:0];
							state_q <= S_PREP;
						end
					end
				end
				S_CMD_MUL: begin
					if (mul_done) begin
						e_q     <= e_cmd;
						dneg_q  <= cmd_neg_q;
						turn_q  <= (cmd_adv_q == MOVE_TURN);
						phase_q <= PH_LATCH;
						state_q <= S_IDLE;
					end
				end
				S_PREP: begin
					// q is progress along the move's own direction
					q_q     <= dneg_q ? (PW + 1)'(-p_x) : p_x;
					aq_q    <= aq_w[PW-1:0];
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					phase_q <= ev_phase;
					flip_q  <= ev_flip;
					case (ev_act)
						ACT_RAMP: begin
							done_q  <= 1'b0;
							state_q <= S_RAMP_MUL;
						end
						ACT_CRUISE: begin
							done_q  <= 1'b0;
							mag_q   <= max_speed_q;
							state_q <= S_OUT;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_OUT;
						end
					endcase
				end
				S_RAMP_MUL: begin
					if (mul_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						mag_q   <= mag_new;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/tmprof_mul.sv
module tmprof_mul #(
	parameter int A_W = 17,
	parameter int B_W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);

	localparam int P_W = A_W + B_W;
	localparam int C_W = $clog2(A_W + 1);

	logic [C_W-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [B_W-1:0] b_q;
	logic [P_W-1:0] acc_q;
	logic [B_W:0]   part;

	// low half holds the remaining multiplier bits, high half the running sum
	assign part = {1'b0, acc_q[P_W-1:A_W]} + (acc_q[0] ? {1'b0, b_q} : {(B_W + 1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= C_W'(A_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - C_W'(1);
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {{B_W{1'b0}}, a};
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= {part, acc_q[A_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

### design/tmprof_div.sv
module tmprof_div #(
	parameter int N_W = 49,
	parameter int D_W = 32,
	parameter int Q_W = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [Q_W-1:0] quo,
	output logic           sat
);

	localparam int C_W = $clog2(N_W + 1);

	logic [C_W-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [N_W-1:0] num_q;
	logic [D_W-1:0] den_q;
	logic [D_W-1:0] rem_q;
	logic [Q_W-1:0] quo_q;
	logic           sat_q;
	logic [D_W:0]   shifted;
	logic [D_W+1:0] trial;
	logic           qbit;

	// restoring division, one numerator bit in per cycle, MSB first
	assign shifted = {rem_q, num_q[N_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign qbit    = !trial[D_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= C_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - C_W'(1);
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[N_W-2:0], 1'b0};
			rem_q <= qbit ? trial[D_W-1:0] : shifted[D_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], qbit};
			// a set bit leaving the top means the quotient is past the kept range
			sat_q <= sat_q | quo_q[Q_W-1];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign sat  = sat_q;

endmodule

### verif/trapezoid_move_profiler_core_tb.sv
module trapezoid_move_profiler_core_tb
	import tmprof_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD        = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int IDLE_PCT      = 6;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 120;
	localparam int QUIET_LIMIT   = 3000;
	localparam int MAX_NOTES     = 40;
	localparam longint DELTA_MAX = 64'sd2147483647;
	localparam longint DELTA_MIN = -64'sd2147483648;

	typedef enum logic [2:0] {
		MV_IDLE,
		MV_LATCH,
		MV_RAMP_UP,
		MV_CRUISE,
		MV_RAMP_DOWN
	} move_phase_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	item_t                 item      = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_t                  res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// profile state as the block should hold it
	move_phase_t               mv_phase     = MV_IDLE;
	bit                        spin_move    = 1'b0;
	logic signed [31:0]        origin_count = '0;
	longint                    move_span    = 0;
	logic [SPEED_W-1:0]        base_speed   = START_SPEED_RST;
	logic [SPEED_W-1:0]        top_speed    = MAX_SPEED_RST;
	logic signed [SCALE_W-1:0] turn_gain    = TURN_SCALE_RST;
	logic signed [SCALE_W-1:0] adv_gain     = ADVANCE_SCALE_RST;

	res_t speed_queue[$];
	res_t want;
	int   slips        = 0;
	int   work_items   = 0;
	int   quiet_cycles = 0;
	bit   steady       = 1'b0;
	bit   hold_request = 1'b0;

	trapezoid_move_profiler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	task automatic note_mismatch(input string what);
		if (slips < MAX_NOTES)
			$display("%0t ns: %s", $time, what);
		slips++;
	endtask

	function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_START_SPEED: base_speed = data[SPEED_W-1:0];
			CFG_MAX_SPEED: top_speed = data[SPEED_W-1:0];
			CFG_TURN_SCALE: turn_gain = data;
			CFG_ADVANCE_SCALE: adv_gain = data;
			default: ;
		endcase
	endfunction

	// One word into the profile; returns 1 when a speed word should come out.
	function automatic bit profile_step(input item_t w, output res_t r);
		longint amt, gain, prod, d, p, q, e, aq, ks, vs, mag, sv;
		logic signed [31:0] diff;
		bit fin;
		r = '0;
		mag = 0;
		fin = 1'b0;
		if (w.kind == KIND_CMD) begin
			amt = longint'(w.amount);
			gain = (w.move_kind == MOVE_ADVANCE) ? longint'(adv_gain) : longint'(turn_gain);
			prod = amt * gain;
			d = prod >>> GAIN_SHIFT;
			if (d > DELTA_MAX)
				d = DELTA_MAX;
			if (d < DELTA_MIN)
				d = DELTA_MIN;
			move_span = d;
			spin_move = (w.move_kind == MOVE_TURN);
			mv_phase = MV_LATCH;
			return 1'b0;
		end
		if (mv_phase == MV_IDLE)
			return 1'b0;
		if (mv_phase == MV_LATCH) begin
			origin_count = w.left_count;
			mv_phase = MV_RAMP_UP;
		end
		diff = w.left_count - origin_count;
		p = longint'(diff);
		ks = longint'(base_speed);
		vs = longint'(top_speed);
		if (move_span == 0) begin
			fin = 1'b1;
		end else begin
			if (move_span > 0) begin
				e = move_span;
				q = p;
			end else begin
				e = -move_span;
				q = -p;
			end
			aq = (q < 0) ? -q : q;
			// phases chain within one tick, never backwards
			if (mv_phase == MV_RAMP_UP) begin
				if (3 * q < e)
					mag = ks + (3 * (vs - ks) * aq) / e;
				else
					mv_phase = MV_CRUISE;
			end
			if (mv_phase == MV_CRUISE) begin
				if (3 * q < 2 * e)
					mag = vs;
				else
					mv_phase = MV_RAMP_DOWN;
			end
			if (mv_phase == MV_RAMP_DOWN) begin
				if (q < e)
					mag = ks + (3 * (vs - ks) * (e - aq)) / e;
				else
					fin = 1'b1;
			end
		end
		if (fin) begin
			mv_phase = MV_IDLE;
			r.done_res = 1'b1;
			return 1'b1;
		end
		if (mag < 0)
			mag = 0;
		if (mag > 32767)
			mag = 32767;
		sv = (move_span > 0) ? mag : -mag;
		r.left_speed = OUT_W'(sv);
		r.right_speed = OUT_W'(spin_move ? -sv : sv);
		return 1'b1;
	endfunction

	// valid is left high after acceptance; the next send or a drain decides
	task automatic send_word(input item_t w);
		res_t r;
		bit got;
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 50);
		end
		item_valid <= 1'b1;
		item <= w;
		do
			@(posedge clk);
		while (item_stall);
		if (w.kind == KIND_CMD || mv_phase != MV_IDLE)
			work_items++;
		got = profile_step(w, r);
		if (got)
			speed_queue.push_back(r);
	endtask

	task automatic send_cmd(input logic mk, input logic signed [AMOUNT_W-1:0] amt);
		item_t w;
		w = '0;
		w.kind = KIND_CMD;
		w.move_kind = mk;
		w.amount = amt;
		w.left_count = $urandom;
		send_word(w);
	endtask

	task automatic send_tick(input logic signed [COUNT_IN_W-1:0] count);
		item_t w;
		w = '0;
		w.kind = KIND_TICK;
		w.move_kind = 1'($urandom);
		w.amount = AMOUNT_W'($urandom);
		w.left_count = count;
		send_word(w);
	endtask

	task automatic await_quiet();
		item_valid <= 1'b0;
		while (speed_queue.size() != 0)
			@(posedge clk);
		// commands and ignored ticks give nothing back but may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		store_reg(idx, data);
	endtask

	task automatic program_regs(input logic [SPEED_W-1:0] ks, input logic [SPEED_W-1:0] vm,
			input logic [SCALE_W-1:0] tg, input logic [SCALE_W-1:0] ag);
		write_reg(CFG_START_SPEED, {(CFG_DATA_W - SPEED_W)'($urandom), ks});
		write_reg(CFG_MAX_SPEED, {(CFG_DATA_W - SPEED_W)'($urandom), vm});
		// out-of-range index must leave every register alone
		write_reg(CFG_IDX_W'($urandom_range(int'(CFG_ADVANCE_SCALE) + 1,
			(1 << CFG_IDX_W) - 1)), $urandom);
		write_reg(CFG_TURN_SCALE, tg);
		write_reg(CFG_ADVANCE_SCALE, ag);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [AMOUNT_W-1:0] pick_amount();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return AMOUNT_W'($signed($urandom_range(0, 800)) - 400);
		else if (r < 90)
			return AMOUNT_W'($signed($urandom_range(0, 40)) - 20);
		return AMOUNT_W'($urandom);
	endfunction

	// Mostly whole moves: command, latch, ticks spread over the span with jitter,
	// then ticks past the end. Some moves are cut short; some words are pure noise.
	task automatic drive_moves(input int budget);
		int stop_at, n_steps, k;
		longint span, base, j, off;
		item_t w;
		stop_at = work_items + budget;
		while (work_items < stop_at) begin
			if ($urandom_range(99) < 15) begin
				w.kind = 1'($urandom);
				w.move_kind = 1'($urandom);
				w.amount = AMOUNT_W'($urandom);
				w.left_count = $urandom;
				send_word(w);
			end else begin
				send_cmd(1'($urandom), pick_amount());
				span = move_span;
				n_steps = $urandom_range(2, 14);
				base = longint'($urandom);
				j = ((span < 0) ? -span : span) / (3 * n_steps) + 2;
				for (k = 0; k <= n_steps + 4 && mv_phase != MV_IDLE; k++) begin
					off = span * k / n_steps;
					if (k > 0 && k < n_steps + 4)
						off += longint'($urandom_range(0, 32'(2 * j))) - j;
					send_tick(COUNT_IN_W'(base + off));
					if ($urandom_range(99) < 3)
						break;
				end
			end
		end
	endtask

	task automatic test_directed();
		send_tick(32'sh1234_5678);
		send_cmd(MOVE_ADVANCE, 16'sd10);
		send_tick(32'sh7fff_ff00);
		send_tick(32'sh7fff_fece);      // encoder behind start
		send_tick(32'sh8000_002c);      // count wraps, 300 ahead
		send_tick(32'sh8000_0158);
		send_tick(32'sh8000_0220);
		send_cmd(MOVE_TURN, -16'sd90);
		send_tick(32'sd5000);
		send_cmd(MOVE_TURN, 16'sd45);   // replaces the running move
		send_tick(32'sd0);
		send_tick(-32'sd500);
		send_tick(-32'sd1000);
		send_tick(-32'sd1400);
		send_cmd(MOVE_ADVANCE, 16'sd0);
		send_tick(32'sd77);
		send_tick(32'sd78);
		send_cmd(MOVE_ADVANCE, 16'sh7fff);
		send_tick(32'sh8000_0000);
		send_tick(32'sh7fff_ffff);
		send_cmd(MOVE_TURN, 16'sh8000);
		send_tick(32'sh7fff_ffff);
		send_tick(32'sh0000_0000);
		await_quiet();
	endtask

	task automatic test_settings();
		program_regs('0, '1, 32'sh0001_0000, -32'sh0001_0000);
		drive_moves(110);
		await_quiet();
		program_regs('1, '0, -32'sd3000000, 32'sd700000);   // ramps run downhill
		drive_moves(110);
		await_quiet();
		program_regs('1, '1, 32'sh8000_0000, 32'sh7fff_ffff);
		drive_moves(110);
		await_quiet();
		program_regs(SPEED_W'($urandom), SPEED_W'($urandom), '0, $urandom);
		drive_moves(110);
		await_quiet();
		program_regs(SPEED_W'($urandom), SPEED_W'($urandom),
			$signed($urandom_range(0, 1 << 23)) - (1 << 22),
			$signed($urandom_range(0, 1 << 23)) - (1 << 22));
		drive_moves(110);
		await_quiet();
		program_regs(START_SPEED_RST, MAX_SPEED_RST, TURN_SCALE_RST, ADVANCE_SCALE_RST);
		drive_moves(110);
		await_quiet();
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		drive_moves(40);
		await_quiet();
	endtask

	task automatic test_random();
		drive_moves(400);
		steady = 1'b1;
		drive_moves(400);
		steady = 1'b0;
		await_quiet();
		program_regs(SPEED_W'($urandom_range(0, 1024)), SPEED_W'($urandom_range(1024, 8192)),
			$signed($urandom_range(0, 1 << 24)) - (1 << 23), $urandom_range(0, 1 << 24));
		drive_moves(400);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) begin
					res_stall <= 1'b1;
					@(posedge clk);
				end
			end
			res_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (speed_queue.size() == 0) begin
				note_mismatch($sformatf("unexpected word %p", res));
			end else begin
				want = speed_queue.pop_front();
				if (res.left_speed !== want.left_speed)
					note_mismatch($sformatf("left_speed %0d, want %0d",
						res.left_speed, want.left_speed));
				if (res.right_speed !== want.right_speed)
					note_mismatch($sformatf("right_speed %0d, want %0d",
						res.right_speed, want.right_speed));
				if (res.done_res !== want.done_res)
					note_mismatch($sformatf("done_res %b, want %b",
						res.done_res, want.done_res));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("trapezoid_move_profiler_core: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_settings();
		test_backpressure();
		test_random();
		await_quiet();
		if (speed_queue.size() != 0)
			note_mismatch($sformatf("%0d speed words never came", speed_queue.size()));
		if (slips == 0)
			$display("trapezoid_move_profiler_core: match");
		else
			$display("trapezoid_move_profiler_core: mismatch");
		$finish;
	end

endmodule

### sim.f
design/tmprof_pkg.sv
design/tmprof_mul.sv
design/tmprof_div.sv
design/trapezoid_move_profiler_core.sv
verif/trapezoid_move_profiler_core_tb.sv
